// ===== design/pvr_pkg.sv =====
// Shared constants, types and a helper function for the packed voxel palette reader.
`timescale 1ns / 1ps

package pvr_pkg;

    // Number of 64-bit words in the packed store.
    localparam int unsigned STORE_WORDS = 65536;
    localparam int unsigned ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    // Widths of the internal datapath.
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned LIN_W   = 32;  // full linear index, never wraps
    localparam int unsigned START_W = 36;  // linear index times field width
    localparam int unsigned WADDR_W = 30;  // word address taken from the bit start
    localparam int unsigned CMP_W   = 31;  // room for word addresses and the store size

    // Item kinds.
    typedef enum logic [0:0] {
        CMD_LOAD   = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_PALETTE_COUNT = 2'd0;
    localparam t_cfg_index CFG_SIZE_X        = 2'd1;
    localparam t_cfg_index CFG_SIZE_Z        = 2'd2;

    // Width of one packed field: bits needed for the palette count, at least two.
    function automatic logic [4:0] field_bits(input logic [16:0] n);
        logic [15:0] m;
        logic [4:0]  b;
        b = 5'd2;
        if (n > 17'd65536) begin
            m = 16'hFFFF;
        end else if (n == 17'd0) begin
            m = 16'd0;
        end else begin
            m = 16'(n - 17'd1);
        end
        for (int i = 2; i < 16; i++) begin
            if (m[i]) begin
                b = 5'(i + 1);
            end
        end
        return b;
    endfunction

endpackage

// ===== design/pvr_if.sv =====
// Valid/ready channel interfaces for item input, result output and configuration.
`timescale 1ns / 1ps

interface pvr_in_if;
    import pvr_pkg::*;
    logic        valid;
    logic        ready;
    t_cmd        cmd;
    logic [15:0] word_addr;
    logic [63:0] word_data;
    logic [9:0]  coord_x;
    logic [9:0]  coord_y;
    logic [9:0]  coord_z;

    modport source (output valid, cmd, word_addr, word_data, coord_x, coord_y, coord_z,
                    input ready);
    modport sink   (input valid, cmd, word_addr, word_data, coord_x, coord_y, coord_z,
                    output ready);
endinterface

interface pvr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] palette_id;
    logic [29:0] linear_index;
    logic        out_of_range;

    modport source (output valid, palette_id, linear_index, out_of_range, input ready);
    modport sink   (input valid, palette_id, linear_index, out_of_range, output ready);
endinterface

interface pvr_cfg_if;
    import pvr_pkg::*;
    logic        valid;
    logic        ready;
    t_cfg_index  index;
    logic [16:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/packed_voxel_palette_index_reader.sv =====
// Top level of the packed voxel palette reader: index pipeline, packed store and field extract.
`timescale 1ns / 1ps

// Streams load and lookup items at one item per clock while the output side takes results.
// A load writes one 64-bit word of the packed store and gives no result; a lookup gives one
// result. The pipeline has seven register stages: two multiplier stages for y*size_x*size_z
// and z*size_x, one adder stage, one stage that scales the index by the field width, one
// address stage, the registered read of the store (two read ports, so a field that spans two
// words needs no second read) and the output register. Each stage holds its item until the
// next one frees up, so stalls collapse bubbles and nothing is dropped or repeated. Items are
// taken in order, so a lookup always sees every load transferred before it. The store is not
// cleared after reset: a lookup of a word that was never loaded returns an undefined id.
// Configuration writes are taken at any time but are meant for periods when no item is in
// flight.

module packed_voxel_palette_index_reader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pvr_in_if.sink      i_in,
    pvr_cfg_if.sink     i_cfg,
    pvr_out_if.source   o_out
);

    import pvr_pkg::*;

    // Configuration registers; the palette count is kept as its field width.
    logic [4:0]  r_field_bits;
    logic [10:0] r_size_x;
    logic [10:0] r_size_z;

    // Stage valid bits and stage advance enables.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

    // Stage 1: first products.
    t_cmd        r1_cmd;
    logic [15:0] r1_addr;
    logic [63:0] r1_data;
    logic [20:0] r1_yx;
    logic [20:0] r1_zx;
    logic [9:0]  r1_x;

    // Stage 2: second product and partial sum.
    t_cmd        r2_cmd;
    logic [15:0] r2_addr;
    logic [63:0] r2_data;
    logic [31:0] r2_yxz;
    logic [21:0] r2_zxx;

    // Stage 3: linear index.
    t_cmd             r3_cmd;
    logic [15:0]      r3_addr;
    logic [63:0]      r3_data;
    logic [LIN_W-1:0] r3_lin;

    // Stage 4: bit start of the field.
    t_cmd               r4_cmd;
    logic [15:0]        r4_addr;
    logic [63:0]        r4_data;
    logic [LIN_W-1:0]   r4_lin;
    logic [START_W-1:0] r4_start;

    // Stage 5: store addresses and range check.
    t_cmd              r5_cmd;
    logic              r5_we;
    logic [ADDR_W-1:0] r5_waddr;
    logic [63:0]       r5_data;
    logic [ADDR_W-1:0] r5_raddr0;
    logic [ADDR_W-1:0] r5_raddr1;
    logic [5:0]        r5_off;
    logic              r5_span;
    logic              r5_oor;
    logic [29:0]       r5_lin;

    // Stage 6: store read data and what the extract needs.
    t_cmd         r6_cmd;
    logic [5:0]   r6_off;
    logic         r6_span;
    logic         r6_oor;
    logic [29:0]  r6_lin;
    logic [63:0]  rd_word0;
    logic [63:0]  rd_word1;

    // Stage 7: output register.
    logic [15:0] r7_id;
    logic [29:0] r7_lin;
    logic        r7_oor;

    // Address stage signals.
    logic [CMP_W-1:0] word_ext;
    logic [CMP_W-1:0] word1_ext;
    logic [CMP_W-1:0] load_ext;
    logic [6:0]       field_end;
    logic             n_span;
    logic             n_oor;

    // Extract signals.
    logic [127:0] pair;
    logic [127:0] shifted;
    logic [15:0]  field_mask;
    logic [15:0]  n_id;

    // Configuration writes; indexes past the list are ignored.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_bits <= field_bits(17'd1);
            r_size_x     <= 11'd1;
            r_size_z     <= 11'd1;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_PALETTE_COUNT) begin
                r_field_bits <= field_bits(i_cfg.data);
            end
            if (i_cfg.index == CFG_SIZE_X) begin
                r_size_x <= i_cfg.data[10:0];
            end
            if (i_cfg.index == CFG_SIZE_Z) begin
                r_size_z <= i_cfg.data[10:0];
            end
        end
    end

    // A stage takes a new item when it is empty or its item moves on.
    assign rdy7 = !r_v7 || o_out.ready;
    assign rdy6 = !r_v6 || rdy7;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign i_in.ready = rdy1;

    // Valid bits travel with the data; loads leave the pipeline after the store stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            if (rdy6) r_v6 <= r_v5;
            if (rdy7) r_v7 <= r_v6 && (r6_cmd == CMD_LOOKUP);
        end
    end

    // Stages 1 to 4: linear index and its bit start.
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_cmd  <= i_in.cmd;
            r1_addr <= i_in.word_addr;
            r1_data <= i_in.word_data;
            r1_yx   <= 21'(i_in.coord_y) * 21'(r_size_x);
            r1_zx   <= 21'(i_in.coord_z) * 21'(r_size_x);
            r1_x    <= i_in.coord_x;
        end
        if (rdy2) begin
            r2_cmd  <= r1_cmd;
            r2_addr <= r1_addr;
            r2_data <= r1_data;
            r2_yxz  <= 32'(r1_yx) * 32'(r_size_z);
            r2_zxx  <= 22'(r1_zx) + 22'(r1_x);
        end
        if (rdy3) begin
            r3_cmd  <= r2_cmd;
            r3_addr <= r2_addr;
            r3_data <= r2_data;
            r3_lin  <= LIN_W'(r2_yxz + 32'(r2_zxx));
        end
        if (rdy4) begin
            r4_cmd   <= r3_cmd;
            r4_addr  <= r3_addr;
            r4_data  <= r3_data;
            r4_lin   <= r3_lin;
            r4_start <= START_W'(r3_lin) * START_W'(r_field_bits);
        end
    end

    // Word addresses, spanning and the range check against the store size.
    always_comb begin
        word_ext  = CMP_W'(r4_start[START_W-1:6]);
        word1_ext = CMP_W'(word_ext + CMP_W'(1));
        load_ext  = CMP_W'(r4_addr);
        field_end = {1'b0, r4_start[5:0]} + {2'b00, r_field_bits};
        n_span    = field_end > 7'd64;
        n_oor     = (word_ext >= CMP_W'(STORE_WORDS))
                 || (n_span && (word1_ext >= CMP_W'(STORE_WORDS)));
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r5_cmd    <= r4_cmd;
            r5_we     <= (r4_cmd == CMD_LOAD) && (load_ext < CMP_W'(STORE_WORDS));
            r5_waddr  <= load_ext[ADDR_W-1:0];
            r5_data   <= r4_data;
            r5_raddr0 <= word_ext[ADDR_W-1:0];
            r5_raddr1 <= word1_ext[ADDR_W-1:0];
            r5_off    <= r4_start[5:0];
            r5_span   <= n_span;
            r5_oor    <= n_oor;
            r5_lin    <= r4_lin[29:0];
        end
    end

    // Packed store: the load writes and the lookup reads as the item leaves stage 5.
    pvr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (r_v5 && rdy6 && r5_we),
        .i_waddr   (r5_waddr),
        .i_wdata   (r5_data),
        .i_re      (rdy6),
        .i_raddr_a (r5_raddr0),
        .i_raddr_b (r5_raddr1),
        .o_rdata_a (rd_word0),
        .o_rdata_b (rd_word1)
    );

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r6_cmd  <= r5_cmd;
            r6_off  <= r5_off;
            r6_span <= r5_span;
            r6_oor  <= r5_oor;
            r6_lin  <= r5_lin;
        end
    end

    // Field extract; the upper word only counts when the field runs into it.
    always_comb begin
        pair       = {(r6_span ? rd_word1 : 64'd0), rd_word0};
        shifted    = pair >> r6_off;
        field_mask = 16'((17'd1 << r_field_bits) - 17'd1);
        n_id       = r6_oor ? 16'd0 : (shifted[15:0] & field_mask);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (rdy7) begin
            r7_id  <= n_id;
            r7_lin <= r6_lin;
            r7_oor <= r6_oor;
        end
    end

    assign o_out.valid        = r_v7;
    assign o_out.palette_id   = r7_id;
    assign o_out.linear_index = r7_lin;
    assign o_out.out_of_range = r7_oor;

endmodule

// ===== design/pvr_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module pvr_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                          o_rdata_a,
    output logic [WIDTH-1:0]                          o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Both read ports hold their data while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
